// ===== src/multichannel_two_pole_iir_assert.svh =====
// assertion macros for the two-pole filter checker
`ifndef MULTICHANNEL_TWO_POLE_IIR_ASSERT_SVH
`define MULTICHANNEL_TWO_POLE_IIR_ASSERT_SVH

// same-cycle implication
`define MTPI_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mtpi check failed");

// next-cycle implication
`define MTPI_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mtpi check failed");

`endif

// ===== src/mtpi_pkg.sv =====
`default_nettype none

package mtpi_pkg;

   localparam int CHANNELS_DEFAULT = 8;
   localparam int CHAN_W           = 3;
   localparam int SAMPLE_W         = 16;
   localparam int COEF_W           = 17;
   localparam int ACC_W            = 32;
   localparam int FRAC_W           = 16;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_INPUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PREV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OLDER = 2'd2;

   localparam logic CMD_SIGNED   = 1'b0;
   localparam logic CMD_UNSIGNED = 1'b1;

   localparam logic [COEF_W-1:0] COEF_INPUT_RESET = 17'h10000;
   localparam logic [COEF_W-1:0] COEF_ZERO        = 17'h00000;

   localparam logic [ACC_W-1:0] TOP_LIMIT = 32'hFFFF0000;

   typedef struct packed {
      logic [COEF_W-1:0] c_in;
      logic [COEF_W-1:0] c_prev;
      logic [COEF_W-1:0] c_old;
   } coef_type;

   typedef struct packed {
      logic [ACC_W-1:0] recent;
      logic [ACC_W-1:0] older;
   } hist_rd_type;

   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] idx;
      logic [ACC_W-1:0]  recent;
      logic [ACC_W-1:0]  older;
   } hist_wr_type;

endpackage

`default_nettype wire

// ===== src/mtpi_hist.sv =====
`default_nettype none

module mtpi_hist #(
   parameter int CHANNELS = mtpi_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [mtpi_pkg::CHAN_W-1:0] rd_idx,
   input  wire mtpi_pkg::hist_wr_type       wr,
   output mtpi_pkg::hist_rd_type            rd
);

   // only channels the channel field can name need storage
   localparam int REACH = 1 << mtpi_pkg::CHAN_W;
   localparam int DEPTH = (CHANNELS < REACH) ? CHANNELS : REACH;

   logic [mtpi_pkg::ACC_W-1:0] recent_ff [DEPTH];
   logic [mtpi_pkg::ACC_W-1:0] older_ff  [DEPTH];
   logic [mtpi_pkg::ACC_W-1:0] recent_in [DEPTH];
   logic [mtpi_pkg::ACC_W-1:0] older_in  [DEPTH];

   always_comb begin
      rd = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (rd_idx == mtpi_pkg::CHAN_W'(i)) begin
            rd.recent = recent_ff[i];
            rd.older  = older_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         recent_in[i] = recent_ff[i];
         older_in[i]  = older_ff[i];
         if (wr.en && (wr.idx == mtpi_pkg::CHAN_W'(i))) begin
            recent_in[i] = wr.recent;
            older_in[i]  = wr.older;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (reset) begin
            recent_ff[i] <= '0;
            older_ff[i]  <= '0;
         end else begin
            recent_ff[i] <= recent_in[i];
            older_ff[i]  <= older_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/mtpi_core.sv =====
`default_nettype none

module mtpi_core (
   input  wire logic                          command,
   input  wire logic [mtpi_pkg::SAMPLE_W-1:0] sample_bits,
   input  wire mtpi_pkg::coef_type            coef,
   input  wire mtpi_pkg::hist_rd_type         hist,
   output logic [mtpi_pkg::ACC_W-1:0]         y_store,
   output logic [mtpi_pkg::SAMPLE_W-1:0]      filtered_bits
);

   localparam int ACC_W  = mtpi_pkg::ACC_W;
   localparam int COEF_W = mtpi_pkg::COEF_W;
   localparam int FRAC_W = mtpi_pkg::FRAC_W;
   localparam int EXT_W  = ACC_W - mtpi_pkg::SAMPLE_W;
   localparam int PROD_W = ACC_W + COEF_W + 2;

   logic                        is_unsigned;
   logic [ACC_W-1:0]            v_ext;
   logic [ACC_W+COEF_W-1:0]     term_in_full;
   logic signed [ACC_W:0]       h1_ext;
   logic signed [ACC_W:0]       h0_ext;
   logic signed [PROD_W-1:0]    p_prev;
   logic signed [PROD_W-1:0]    p_old;
   logic [ACC_W-1:0]            y_sum;

   assign is_unsigned = (command == mtpi_pkg::CMD_UNSIGNED);

   always_comb begin
      if (is_unsigned) begin
         v_ext  = {{EXT_W{1'b0}}, sample_bits};
         h1_ext = $signed({1'b0, hist.recent});
         h0_ext = $signed({1'b0, hist.older});
      end else begin
         v_ext  = {{EXT_W{sample_bits[mtpi_pkg::SAMPLE_W-1]}}, sample_bits};
         h1_ext = $signed({hist.recent[ACC_W-1], hist.recent});
         h0_ext = $signed({hist.older[ACC_W-1], hist.older});
      end
   end

   // low word of the input product does not depend on the sign view
   assign term_in_full = v_ext * coef.c_in;
   assign p_prev       = h1_ext * $signed({1'b0, coef.c_prev});
   assign p_old        = h0_ext * $signed({1'b0, coef.c_old});

   assign y_sum = term_in_full[ACC_W-1:0]
                + p_prev[ACC_W+FRAC_W-1:FRAC_W]
                + p_old[ACC_W+FRAC_W-1:FRAC_W];

   always_comb begin
      if (is_unsigned && (y_sum >= mtpi_pkg::TOP_LIMIT)) begin
         y_store = '0;
      end else begin
         y_store = y_sum;
      end
      if (y_store >= mtpi_pkg::TOP_LIMIT) begin
         filtered_bits = '0;
      end else begin
         filtered_bits = y_store[ACC_W-1:FRAC_W];
      end
   end

endmodule

`default_nettype wire

// ===== src/multichannel_two_pole_iir.sv =====
// an accepted word passes the input stage registers, then the result registers
// throughput: one word per cycle if unstalled, set by the single arithmetic stage
//   (three 32x17 products and a three-way add) between input and result registers
// back-to-back words on one channel see each other's history with no bubble
// reset (synchronous, active high) clears all history, empties the pipeline
//   and loads the coefficient defaults
`default_nettype none

module multichannel_two_pole_iir #(
   parameter int CHANNELS = mtpi_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_command,
   input  wire logic [mtpi_pkg::CHAN_W-1:0]    req_channel,
   input  wire logic [mtpi_pkg::SAMPLE_W-1:0]  req_sample_bits,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [mtpi_pkg::SAMPLE_W-1:0]       rsp_filtered_bits,
   input  wire logic                           csr_write_enable,
   input  wire logic [mtpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mtpi_pkg::COEF_W-1:0]    csr_data
);

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            s1_cmd_ff;
   logic                            s1_cmd_in;
   logic [mtpi_pkg::CHAN_W-1:0]     s1_chan_ff;
   logic [mtpi_pkg::CHAN_W-1:0]     s1_chan_in;
   logic [mtpi_pkg::SAMPLE_W-1:0]   s1_sample_ff;
   logic [mtpi_pkg::SAMPLE_W-1:0]   s1_sample_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [mtpi_pkg::SAMPLE_W-1:0]   rsp_data_ff;
   logic [mtpi_pkg::SAMPLE_W-1:0]   rsp_data_in;
   mtpi_pkg::coef_type              coef_ff;
   mtpi_pkg::coef_type              coef_in;

   logic                            out_free;
   logic                            advance;
   logic                            take;
   logic                            in_range;
   mtpi_pkg::hist_rd_type           hist_rd;
   mtpi_pkg::hist_wr_type           hist_wr;
   logic [mtpi_pkg::ACC_W-1:0]      y_store;
   logic [mtpi_pkg::SAMPLE_W-1:0]   filtered;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign in_range  = (32'(s1_chan_ff) < CHANNELS);

   mtpi_hist #(
      .CHANNELS (CHANNELS)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (s1_chan_ff),
      .wr     (hist_wr),
      .rd     (hist_rd)
   );

   mtpi_core u_core (
      .command       (s1_cmd_ff),
      .sample_bits   (s1_sample_ff),
      .coef          (coef_ff),
      .hist          (hist_rd),
      .y_store       (y_store),
      .filtered_bits (filtered)
   );

   always_comb begin
      hist_wr.en     = advance && in_range;
      hist_wr.idx    = s1_chan_ff;
      hist_wr.recent = y_store;
      hist_wr.older  = hist_rd.recent;
   end

   always_comb begin
      s1_valid_in  = take || (s1_valid_ff && !advance);
      s1_cmd_in    = take ? req_command     : s1_cmd_ff;
      s1_chan_in   = take ? req_channel     : s1_chan_ff;
      s1_sample_in = take ? req_sample_bits : s1_sample_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      if (advance) begin
         rsp_data_in = in_range ? filtered : '0;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_comb begin
      coef_in = coef_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mtpi_pkg::CSR_COEF_INPUT: coef_in.c_in   = csr_data;
            mtpi_pkg::CSR_COEF_PREV:  coef_in.c_prev = csr_data;
            mtpi_pkg::CSR_COEF_OLDER: coef_in.c_old  = csr_data;
            default:                  coef_in        = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         coef_ff.c_in   <= mtpi_pkg::COEF_INPUT_RESET;
         coef_ff.c_prev <= mtpi_pkg::COEF_ZERO;
         coef_ff.c_old  <= mtpi_pkg::COEF_ZERO;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         coef_ff        <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff    <= s1_cmd_in;
      s1_chan_ff   <= s1_chan_in;
      s1_sample_ff <= s1_sample_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_bits = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/mtpi_checker.sv =====
`default_nettype none

`include "multichannel_two_pole_iir_assert.svh"

module mtpi_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [mtpi_pkg::SAMPLE_W-1:0]  rsp_filtered_bits
);

   // input side only backs up when a result word is blocked
   `MTPI_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // an accepted word is followed by a result word being offered on the result side
   `MTPI_ASSERT_IMPLIES(a_word_arrives, clock, reset, req_valid && !req_stall, ##2 rsp_valid)

   // no result word right after reset
   `MTPI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled result word stays offered
   `MTPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result word keeps its value
   `MTPI_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_filtered_bits))

endmodule

bind multichannel_two_pole_iir mtpi_checker u_mtpi_checker (.*);

`default_nettype wire
